@@ rtl/core/mac_translation_table_defines.svh @@
// Assertion macros used by the MAC translation table RTL.
`ifndef MAC_TRANSLATION_TABLE_DEFINES_SVH
`define MAC_TRANSLATION_TABLE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define MTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define MTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mtt_pkg.sv @@
// Types, codes and helper functions of the MAC translation table.
package mtt_pkg;

    // Request opcodes.
    typedef enum logic
    {
        OP_LEARN  = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    // Result status codes.
    typedef enum logic [1:0]
    {
        ST_LEARNED = 2'd0,
        ST_REFUSED = 2'd1,
        ST_HIT     = 2'd2,
        ST_MISS    = 2'd3
    } status_t;

    // One request transfer.
    typedef struct packed
    {
        opcode_t     opcode;
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [47:0] station_mac;
    } req_t;

    // One response transfer.
    typedef struct packed
    {
        status_t     status;
        logic [47:0] result_mac;
    } rsp_t;

    // One table entry as stored in the RAM.
    typedef struct packed
    {
        logic        valid;
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [47:0] mac;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Presence map and MAC constants.
    localparam int MAP_BITS  = 64;
    localparam int MAP_IDX_W = 6;
    localparam int MCAST_BIT = 40;

    // Slot hash: a 32-bit word reduced a few bits per cycle.
    localparam int HASH_W          = 32;
    localparam int HASH_BITS_STEP  = 4;
    localparam int HASH_CYCLES     = HASH_W / HASH_BITS_STEP;
    localparam int HASH_CNT_W      = $clog2(HASH_CYCLES);

    // Builds the hash word from the last four IP bytes, reversed, XORed with
    // proxy MAC bytes 2 to 5.
    function automatic logic [HASH_W-1:0] hash_word(input logic [63:0] ip_low,
                                                    input logic [47:0] proxy);
        hash_word = {ip_low[7:0]   ^ proxy[31:24],
                     ip_low[15:8]  ^ proxy[23:16],
                     ip_low[23:16] ^ proxy[15:8],
                     ip_low[31:24] ^ proxy[7:0]};
    endfunction

endpackage

@@ rtl/core/mtt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module mtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/mac_translation_table.sv @@
// MAC translation table top level: maps a station's 128-bit IP address to its
// original MAC address for a wireless MAC proxy. A learn request stores the
// station MAC under the IP, a lookup request addressed to the proxy MAC returns
// it. One request is worked on at a time. After an accepted request the home
// slot is reduced from a 32-bit hash word by a shared remainder unit, four bits
// per cycle, then a check state decides refusals and quick misses, then each
// visited table slot takes a RAM read state and a compare state, and a result
// state hands the result to the response register. The next request is
// accepted as soon as the result has moved to the response register, even
// while that response is still stalled. After reset a clearing pass marks
// every RAM entry invalid; requests are stalled during it, while
// configuration writes are taken as ever.
`include "mac_translation_table_defines.svh"

module mac_translation_table
    import mtt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req_data,
    // Response channel.
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W:0]   MOD_N       = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] SLOT_LAST   = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] PROBE_LIMIT = CNT_W'(TABLE_ENTRIES);
    localparam logic [HASH_CNT_W-1:0] HASH_LAST = HASH_CNT_W'(HASH_CYCLES - 1);

    // Register index of proxy_mac, taken from paddr bit 3 (8-byte registers).
    localparam logic REG_PROXY_MAC = 1'b0;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_RESULT
    } state_t;

    // Control registers.
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [HASH_CNT_W-1:0]   hash_cnt_reg, hash_cnt_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]        probe_cnt_reg, probe_cnt_next;
    logic [MAP_BITS-1:0]     map_reg, map_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_data_reg, rsp_data_next;
    rsp_t                    res_reg, res_next;
    logic [47:0]             proxy_mac_reg;

    // Request payload registers.
    req_t                    req_reg;
    logic [HASH_W-1:0]       word_reg;
    logic [IDX_W-1:0]        rem_reg;
    logic [MAP_IDX_W-1:0]    map_idx_reg;

    // Datapath signals.
    logic                    req_accept;
    logic                    cfg_write;
    logic [IDX_W-1:0]        rem_step;
    logic [IDX_W:0]          trial;
    logic [IDX_W+MAP_IDX_W-1:0] rem_wide;
    logic [MAP_IDX_W-1:0]    map_idx;
    logic                    mac_mcast;
    logic                    mac_is_proxy;
    entry_t                  rd_entry;
    entry_t                  wr_entry;
    logic                    ip_match;
    logic                    probe_done;
    logic [IDX_W-1:0]        slot_inc;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;

    // Configuration port: always ready, single proxy MAC register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == REG_PROXY_MAC) ? {16'd0, proxy_mac_reg} : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proxy_mac_reg <= 48'd0;
        end
        else if (cfg_write && (paddr[3] == REG_PROXY_MAC))
        begin
            proxy_mac_reg <= pwdata[47:0];
        end
    end

    // Handshake outputs.
    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    // Shared remainder unit: four restoring steps of hash word modulo table size.
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int k = 0; k < HASH_BITS_STEP; k++)
        begin
            trial = {rem_step, word_reg[HASH_W-1-k]};
            if (trial >= MOD_N)
            begin
                trial = trial - MOD_N;
            end
            rem_step = trial[IDX_W-1:0];
        end
    end

    // Presence map bit from the low bits of the home slot.
    assign rem_wide = {{MAP_IDX_W{1'b0}}, rem_reg};
    assign map_idx  = rem_wide[MAP_IDX_W-1:0];

    // Request classification.
    assign mac_mcast    = req_reg.station_mac[MCAST_BIT];
    assign mac_is_proxy = (req_reg.station_mac == proxy_mac_reg);

    // Probe compare on the registered RAM read.
    assign rd_entry   = entry_t'(ram_rdata);
    assign ip_match   = (rd_entry.ip_high == req_reg.ip_high)
                        && (rd_entry.ip_low == req_reg.ip_low);
    assign probe_done = (probe_cnt_reg == PROBE_LIMIT) || !rd_entry.valid;
    assign slot_inc   = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;

    // Entry written by a learn.
    always_comb
    begin
        wr_entry.valid   = 1'b1;
        wr_entry.ip_high = req_reg.ip_high;
        wr_entry.ip_low  = req_reg.ip_low;
        wr_entry.mac     = req_reg.station_mac;
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        hash_cnt_next  = hash_cnt_reg;
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        map_next       = map_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = wr_entry;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
                if (clr_idx_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_accept)
                begin
                    hash_cnt_next = '0;
                    state_next    = S_HASH;
                end
            end
            S_HASH:
            begin
                hash_cnt_next = hash_cnt_reg + 1'b1;
                if (hash_cnt_reg == HASH_LAST)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                slot_next           = rem_reg;
                probe_cnt_next      = '0;
                res_next.result_mac = req_reg.station_mac;
                if (req_reg.opcode == OP_LEARN)
                begin
                    if (mac_mcast || mac_is_proxy)
                    begin
                        res_next.status = ST_REFUSED;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_PROBE_RD;
                    end
                end
                else if ((map_reg == '0) || mac_mcast || !mac_is_proxy
                         || !map_reg[map_idx])
                begin
                    res_next.status = ST_MISS;
                    state_next      = S_RESULT;
                end
                else
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:
            begin
                // RAM read of slot_reg is under way.
                state_next = S_PROBE_CMP;
            end
            S_PROBE_CMP:
            begin
                if (req_reg.opcode == OP_LEARN)
                begin
                    if (probe_done || ip_match)
                    begin
                        ram_we                 = 1'b1;
                        map_next[map_idx_reg]  = 1'b1;
                        res_next.status        = ST_LEARNED;
                        state_next             = S_RESULT;
                    end
                    else
                    begin
                        slot_next      = slot_inc;
                        probe_cnt_next = probe_cnt_reg + 1'b1;
                        state_next     = S_PROBE_RD;
                    end
                end
                else if (probe_done)
                begin
                    res_next.status = ST_MISS;
                    state_next      = S_RESULT;
                end
                else if (ip_match)
                begin
                    res_next.status     = ST_HIT;
                    res_next.result_mac = rd_entry.mac;
                    state_next          = S_RESULT;
                end
                else
                begin
                    slot_next      = slot_inc;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    state_next     = S_PROBE_RD;
                end
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            hash_cnt_reg  <= '0;
            slot_reg      <= '0;
            probe_cnt_reg <= '0;
            map_reg       <= '0;
            res_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            hash_cnt_reg  <= hash_cnt_next;
            slot_reg      <= slot_next;
            probe_cnt_reg <= probe_cnt_next;
            map_reg       <= map_next;
            res_reg       <= res_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    // Request payload and hash word; while hashing, the word shifts out four bits per cycle.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg  <= req_data;
            word_reg <= hash_word(req_data.ip_low, proxy_mac_reg);
            rem_reg  <= '0;
        end
        else if (state_reg == S_HASH)
        begin
            word_reg <= word_reg << HASH_BITS_STEP;
            rem_reg  <= rem_step;
        end
        if (state_reg == S_CHECK)
        begin
            map_idx_reg <= map_idx;
        end
    end

    // Entry storage: valid, IP and MAC per slot.
    mtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // A table write happens only during the clearing pass or for a learn.
    `MTT_ASSERT_NOW(a_write_source, ram_we, (state_reg == S_CLEAR) || (req_reg.opcode == OP_LEARN), "table write outside clear pass or learn")

    // A learn that writes the table leaves its presence bit set.
    `MTT_ASSERT_NEXT(a_learn_sets_map, ram_we && (state_reg == S_PROBE_CMP), map_reg[map_idx_reg], "learn did not set presence bit")

    // The probe count never exceeds the table size.
    `MTT_ASSERT_NOW(a_probe_bound, state_reg == S_PROBE_CMP, probe_cnt_reg <= PROBE_LIMIT, "probe count beyond table size")

    // A loaded response matches the request opcode.
    `MTT_ASSERT_NEXT(a_status_opcode, (state_reg == S_RESULT) && (state_next == S_IDLE), (req_reg.opcode == OP_LEARN) == ((rsp_data_reg.status == ST_LEARNED) || (rsp_data_reg.status == ST_REFUSED)), "response status does not match opcode")

endmodule
